@@ design/assert_macros.svh @@
// Assertion macros shared by the timer expiry queue design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TEQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define TEQ_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define TEQ_ASSERT(lbl, prop)
`define TEQ_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

@@ design/teq_pkg.sv @@
// Types and constants of the timer expiry queue.
package teq_pkg;
  localparam int DefCapacity = 16;
  localparam int TimeBits    = 48;
  localparam int TagBits     = 32;
  localparam int DelayBits   = 32;
  localparam int CountBits   = 5;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpCancel = 2'd1;
  localparam logic [1:0] OpCheck  = 2'd2;

  typedef struct packed {
    logic [1:0]           operation;
    logic [TimeBits-1:0]  now_time;
    logic [DelayBits-1:0] delay;
    logic [TagBits-1:0]   cancel_id;
    logic [TimeBits-1:0]  cancel_expiry;
  } teq_req_t;

  typedef struct packed {
    logic                 op_ok;
    logic [TagBits-1:0]   timer_tag;
    logic [TimeBits-1:0]  expiry_out;
    logic                 queue_empty;
    logic [TimeBits-1:0]  wait_ticks;
    logic [CountBits-1:0] pending_count;
  } teq_res_t;
endpackage

@@ design/timer_expiry_queue_top.sv @@
// Top level of the timer expiry queue: memory-held timers scanned per operation.
//
//  Channel  | Direction | Handshake            | Beat
//  ---------+-----------+----------------------+---------------------------
//  request  | in        | start_i while !busy_o | teq_req_t on req_i
//  result   | out       | done_o, one cycle    | teq_res_t on res_o
//
// After the accepting edge busy_o stays high through ST_SCAN1, ST_APPLY,
// ST_SCAN2 and ST_DONE, the last of which carries the result beat on done_o.
// Each of the two scans walks the entry memory one entry per cycle, with the
// synchronous read registered ahead of the compare. The first finds a match,
// a free slot and the earliest timer, ST_APPLY then applies the update, and
// the second finds the new earliest timer. The next beat can be accepted in
// the cycle after the result, so a new operation starts only after the last
// is done. Reset clears the valid bits, the count and the tag counter; no
// clearing pass is needed. The receiver cannot stall the result beat.
`include "assert_macros.svh"
module timer_expiry_queue_top
  import teq_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  teq_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output teq_res_t res_o
);
  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN1 = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_SCAN2 = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Entry memories, synchronous read.
  logic [TimeBits-1:0] exp_mem [CAPACITY];
  logic [TagBits-1:0]  tag_mem [CAPACITY];
  logic [TimeBits-1:0] rd_exp_q;
  logic [TagBits-1:0]  rd_tag_q;
  logic [IdxW-1:0]     raddr;
  logic                we;
  logic [IdxW-1:0]     waddr;

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [TagBits-1:0]  tag_ctr_q, tag_ctr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  // Captured request and search key.
  logic [1:0]          op_q;
  logic [TimeBits-1:0] now_q;
  logic [TimeBits-1:0] key_e_q;
  logic [TagBits-1:0]  key_t_q;

  // Scan trackers.
  logic                found_q, found_d;
  logic [IdxW-1:0]     found_idx_q, found_idx_d;
  logic                free_ok_q, free_ok_d;
  logic [IdxW-1:0]     free_idx_q, free_idx_d;
  logic                best_v_q, best_v_d;
  logic [TimeBits-1:0] best_e_q, best_e_d;
  logic [TagBits-1:0]  best_t_q, best_t_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;

  // Result registers.
  logic                ok_q, ok_d;
  logic [TagBits-1:0]  rtag_q, rtag_d;
  logic [TimeBits-1:0] rexp_q, rexp_d;

  logic [TimeBits:0]   sum_full;
  logic [TimeBits-1:0] sum_sat;
  logic [CntW-1:0]     pcnt;
  logic [IdxW-1:0]     pidx;
  logic                scanning, ent_v, earlier;

  assign sum_full = {1'b0, req_i.now_time} + {{(TimeBits + 1 - DelayBits){1'b0}}, req_i.delay};
  assign sum_sat  = sum_full[TimeBits] ? {TimeBits{1'b1}} : sum_full[TimeBits-1:0];

  assign raddr    = cnt_q[IdxW-1:0];
  assign pcnt     = cnt_q - CntW'(1);
  assign pidx     = pcnt[IdxW-1:0];
  assign scanning = (state_q == ST_SCAN1) || (state_q == ST_SCAN2);
  assign ent_v    = valid_q[pidx];
  assign earlier  = (rd_exp_q < best_e_q) || ((rd_exp_q == best_e_q) && (rd_tag_q < best_t_q));

  always_ff @(posedge clk_i) begin
    if (we) begin
      exp_mem[waddr] <= key_e_q;
      tag_mem[waddr] <= key_t_q;
    end
    rd_exp_q <= exp_mem[raddr];
    rd_tag_q <= tag_mem[raddr];
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    count_d     = count_q;
    tag_ctr_d   = tag_ctr_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    best_v_d    = best_v_q;
    best_e_d    = best_e_q;
    best_t_d    = best_t_q;
    best_idx_d  = best_idx_q;
    ok_d        = ok_q;
    rtag_d      = rtag_q;
    rexp_d      = rexp_q;
    we          = 1'b0;
    waddr       = free_idx_q;

    // One memory entry is examined per cycle during a scan.
    if (scanning && (cnt_q != '0)) begin
      if (!ent_v && !free_ok_q) begin
        free_ok_d  = 1'b1;
        free_idx_d = pidx;
      end
      if (ent_v && !found_q && (rd_tag_q == key_t_q) && (rd_exp_q == key_e_q)) begin
        found_d     = 1'b1;
        found_idx_d = pidx;
      end
      if (ent_v && (!best_v_q || earlier)) begin
        best_v_d   = 1'b1;
        best_e_d   = rd_exp_q;
        best_t_d   = rd_tag_q;
        best_idx_d = pidx;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          state_d   = ST_SCAN1;
          found_d   = 1'b0;
          free_ok_d = 1'b0;
          best_v_d  = 1'b0;
          if (req_i.operation == OpAdd) begin
            tag_ctr_d = tag_ctr_q + TagBits'(1);
          end
        end
      end
      ST_SCAN1, ST_SCAN2: begin
        if (cnt_q == CntW'(CAPACITY)) begin
          cnt_d   = '0;
          state_d = (state_q == ST_SCAN1) ? ST_APPLY : ST_DONE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_APPLY: begin
        state_d  = ST_SCAN2;
        best_v_d = 1'b0;
        ok_d     = 1'b0;
        rtag_d   = '0;
        rexp_d   = '0;
        priority if (op_q == OpAdd) begin
          rtag_d = key_t_q;
          rexp_d = key_e_q;
          if ((count_q < CntW'(CAPACITY)) && !found_q && free_ok_q) begin
            we                 = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            count_d            = count_q + CntW'(1);
            ok_d               = 1'b1;
          end
        end else if (op_q == OpCancel) begin
          if (found_q) begin
            valid_d[found_idx_q] = 1'b0;
            count_d              = count_q - CntW'(1);
            ok_d                 = 1'b1;
          end
        end else if (op_q == OpCheck) begin
          if (best_v_q && (best_e_q <= now_q)) begin
            valid_d[best_idx_q] = 1'b0;
            count_d             = count_q - CntW'(1);
            ok_d                = 1'b1;
            rtag_d              = best_t_q;
            rexp_d              = best_e_q;
          end
        end else begin
          ok_d = 1'b0;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      count_q   <= '0;
      tag_ctr_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
      tag_ctr_q <= tag_ctr_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start_i) begin
      op_q  <= req_i.operation;
      now_q <= req_i.now_time;
      if (req_i.operation == OpAdd) begin
        key_e_q <= sum_sat;
        key_t_q <= tag_ctr_q + TagBits'(1);
      end else begin
        key_e_q <= req_i.cancel_expiry;
        key_t_q <= req_i.cancel_id;
      end
    end
    found_q     <= found_d;
    found_idx_q <= found_idx_d;
    free_ok_q   <= free_ok_d;
    free_idx_q  <= free_idx_d;
    best_v_q    <= best_v_d;
    best_e_q    <= best_e_d;
    best_t_q    <= best_t_d;
    best_idx_q  <= best_idx_d;
    ok_q        <= ok_d;
    rtag_q      <= rtag_d;
    rexp_q      <= rexp_d;
  end

  // The result beat: op_ok, tag and expiry come from the apply step, queue_empty and wait_ticks from the second scan.
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  always_comb begin
    res_o.op_ok         = ok_q;
    res_o.timer_tag     = rtag_q;
    res_o.expiry_out    = rexp_q;
    res_o.queue_empty   = !best_v_q;
    res_o.wait_ticks    = (best_v_q && (best_e_q > now_q)) ? (best_e_q - now_q) : '0;
    res_o.pending_count = CountBits'({{CountBits{1'b0}}, count_q});
  end

  `TEQ_ASSERT(a_count_matches_valid, $countones(valid_q) == count_q)
  `TEQ_ASSERT(a_count_bounded, count_q <= CntW'(CAPACITY))
  `TEQ_ASSERT_MSG(a_done_then_idle, done_o |=> !busy_o, "result beat not followed by idle")
  `TEQ_ASSERT_MSG(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accepted beat did not start work")
endmodule
